>>> rtl/core/css_pkg.sv
package css_pkg;

  localparam int PHASE_W = 4;
  localparam int FAULT_W = 5;
  localparam int CMD_W   = 14;
  localparam int RES_W   = 2;
  localparam int TQ_W    = 16;
  localparam int LIMIT_W = 15;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(240);

  // sequence phases
  localparam logic [PHASE_W-1:0] PH_CHIP_INIT    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_INIT         = 4'd1;
  localparam logic [PHASE_W-1:0] PH_INIT_DONE    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_OVP          = 4'd3;
  localparam logic [PHASE_W-1:0] PH_OVP_DONE     = 4'd4;
  localparam logic [PHASE_W-1:0] PH_PREFLUX      = 4'd5;
  localparam logic [PHASE_W-1:0] PH_PREFLUX_DONE = 4'd6;
  localparam logic [PHASE_W-1:0] PH_TQ_OUT       = 4'd7;
  localparam logic [PHASE_W-1:0] PH_TQ_DONE      = 4'd8;
  localparam logic [PHASE_W-1:0] PH_DISCHG       = 4'd9;
  localparam logic [PHASE_W-1:0] PH_DISCHG_DONE  = 4'd10;
  localparam logic [PHASE_W-1:0] PH_FAULT        = 4'd11;

  // host command bit positions
  localparam int CMD_OVP_EN    = 1;
  localparam int CMD_CLEAR     = 3;
  localparam int CMD_OPEN      = 4;
  localparam int CMD_OPEN_HL   = 5;
  localparam int CMD_PREFLUX   = 6;
  localparam int CMD_TQ_EN     = 7;
  localparam int CMD_TQ_FIN    = 8;
  localparam int CMD_STOP      = 9;
  localparam int CMD_STOP_DONE = 10;
  localparam int CMD_START_AGN = 11;
  localparam int CMD_RESTART   = 12;
  localparam int CMD_HW_DONE   = 13;

  // fault flag bit positions
  localparam int FLT_PHASE   = 0;
  localparam int FLT_INIT    = 1;
  localparam int FLT_OVP     = 2;
  localparam int FLT_PREFLUX = 3;
  localparam int FLT_DISCHG  = 4;

  // tri-state test results; anything else reads as pending
  localparam logic [RES_W-1:0] RES_FAIL = 2'd0;
  localparam logic [RES_W-1:0] RES_OK   = 2'd1;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [FAULT_W-1:0] faults;
    logic               init_ready;
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]      host_command;
    logic                  init_fault;
    logic [RES_W-1:0]      ovp_test_result;
    logic [RES_W-1:0]      preflux_result;
    logic [RES_W-1:0]      discharge_result;
    logic signed [TQ_W-1:0] torque_command;
  } tick_t;

endpackage

>>> rtl/core/css_next_state.sv
module css_next_state (
  input  css_pkg::state_t                    cur,
  input  css_pkg::tick_t                     tick,
  input  logic [css_pkg::LIMIT_W-1:0]        torque_finish_limit,
  output css_pkg::state_t                    nxt
);
  import css_pkg::*;

  logic [TQ_W:0]        tq_mag;
  logic                 tq_small;
  logic                 open;
  logic                 dflt;
  logic [CMD_W-1:0]     cmd;
  logic [PHASE_W-1:0]   ph;
  logic [FAULT_W-1:0]   flt;
  logic                 rdy;

  assign cmd = tick.host_command;
  assign open = cmd[CMD_OPEN] | cmd[CMD_OPEN_HL];
  assign dflt = cur.faults[FLT_DISCHG];

  // 17-bit magnitude so that the most negative value never passes
  assign tq_mag = tick.torque_command[TQ_W-1]
                  ? (TQ_W+1)'(0) - {tick.torque_command[TQ_W-1], tick.torque_command}
                  : {1'b0, tick.torque_command};
  assign tq_small = tq_mag < {{(TQ_W+1-LIMIT_W){1'b0}}, torque_finish_limit};

  always_comb begin
    ph  = cur.phase;
    flt = cur.faults;
    rdy = cur.init_ready;
    case (cur.phase)
      PH_INIT: begin
        if (cur.init_ready) begin
          if (!tick.init_fault) begin
            ph = PH_INIT_DONE;
          end else begin
            ph = PH_FAULT;
            flt[FLT_INIT] = 1'b1;
          end
        end
      end
      PH_INIT_DONE: begin
        if (open) ph = PH_DISCHG;
        else if (cmd[CMD_RESTART]) ph = PH_CHIP_INIT;
        else if (cmd[CMD_OVP_EN]) ph = PH_OVP;
      end
      PH_OVP: begin
        if (open) begin
          ph = PH_DISCHG;
        end else if (tick.ovp_test_result == RES_OK) begin
          ph = PH_OVP_DONE;
        end else if (tick.ovp_test_result == RES_FAIL) begin
          ph = PH_FAULT;
          flt[FLT_OVP] = 1'b1;
        end
      end
      PH_OVP_DONE: begin
        if (open) ph = PH_DISCHG;
        else if (cmd[CMD_PREFLUX]) ph = PH_PREFLUX;
      end
      PH_PREFLUX: begin
        if (open) begin
          ph = PH_DISCHG;
        end else if (cmd[CMD_TQ_FIN]) begin
          // refused finish holds the phase
          if (tq_small) ph = PH_TQ_DONE;
        end else if (tick.preflux_result == RES_OK) begin
          ph = PH_PREFLUX_DONE;
        end else if (tick.preflux_result == RES_FAIL) begin
          ph = PH_FAULT;
          flt[FLT_PREFLUX] = 1'b1;
        end
      end
      PH_PREFLUX_DONE: begin
        if (open) begin
          ph = PH_DISCHG;
        end else if (cmd[CMD_TQ_FIN]) begin
          if (tq_small) ph = PH_TQ_DONE;
        end else if (cmd[CMD_TQ_EN]) begin
          ph = PH_TQ_OUT;
        end
      end
      PH_TQ_OUT: begin
        if (open) begin
          ph = PH_DISCHG;
        end else if (cmd[CMD_TQ_FIN]) begin
          if (tq_small) ph = PH_TQ_DONE;
        end
      end
      PH_TQ_DONE: begin
        if (open) ph = PH_DISCHG;
        else if (cmd[CMD_START_AGN]) ph = PH_INIT_DONE;
        else if (cmd[CMD_STOP]) ph = PH_OVP_DONE;
        else if (cmd[CMD_PREFLUX]) ph = PH_PREFLUX;
      end
      PH_DISCHG: begin
        if (tick.discharge_result == RES_OK) begin
          ph = PH_DISCHG_DONE;
        end else if (tick.discharge_result == RES_FAIL) begin
          ph = PH_FAULT;
          flt[FLT_DISCHG] = 1'b1;
        end
      end
      PH_DISCHG_DONE: begin
        if (cmd[CMD_STOP_DONE] | cmd[CMD_START_AGN]) ph = PH_INIT_DONE;
      end
      PH_FAULT: begin
        if (dflt && cmd[CMD_OPEN_HL]) begin
          ph = PH_DISCHG_DONE;
          flt[FLT_DISCHG] = 1'b0;
        end else if (open && !dflt) begin
          ph = PH_DISCHG;
          flt[FLT_PREFLUX] = 1'b0;
          flt[FLT_OVP] = 1'b0;
        end else if (cmd[CMD_TQ_FIN] && !dflt) begin
          ph = PH_TQ_DONE;
        end else if (cmd[CMD_RESTART]) begin
          ph = PH_CHIP_INIT;
        end
      end
      PH_CHIP_INIT: begin
        flt = '0;
        rdy = 1'b0;
        if (cmd[CMD_HW_DONE]) ph = PH_INIT;
      end
      default: begin
        // invalid phase code: hold and flag it
        flt[FLT_PHASE] = 1'b1;
      end
    endcase
    if (cmd[CMD_CLEAR]) flt = '0;
    if (ph == PH_INIT) rdy = 1'b1;
  end

  assign nxt.phase      = ph;
  assign nxt.faults     = flt;
  assign nxt.init_ready = rdy;

endmodule

>>> rtl/core/converter_startup_sequencer.sv
// Converter startup sequencer.
//
// Input channel (in_valid/in_ready) carries one supervisory tick: host
// command word, init fault flag, OVP/preflux/discharge results and the
// torque command. Output channel (out_valid/out_ready) returns, for every
// tick, the new phase, the fault flags and the inverter enable.
// The torque finish limit is written through cfg_write_en/cfg_write_data;
// the user must do so only while the block is idle; it is not enforced.
//
// A tick passes the input register, then the state register that
// also drives the outputs. Throughput: one tick per cycle while the
// receiver does not stall; the phase transition is a single pass of logic
// between the two registers.
//
// Reset: phase chip init, faults and init ready clear, limit 240, both
// stages empty. When the receiver stalls, the result holds and one more
// tick waits in the input register; in_ready then drops until out_ready.
module converter_startup_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [css_pkg::LIMIT_W-1:0]        cfg_write_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [css_pkg::CMD_W-1:0]          host_command,
  input  logic                               init_fault,
  input  logic [css_pkg::RES_W-1:0]          ovp_test_result,
  input  logic [css_pkg::RES_W-1:0]          preflux_result,
  input  logic [css_pkg::RES_W-1:0]          discharge_result,
  input  logic signed [css_pkg::TQ_W-1:0]    torque_command,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [css_pkg::PHASE_W-1:0]        phase,
  output logic [css_pkg::FAULT_W-1:0]        fault_flags,
  output logic                               inverter_enable
);
  import css_pkg::*;

  logic [LIMIT_W-1:0] torque_finish_limit;
  logic               tick_valid;
  tick_t              tick;
  state_t             state;
  state_t             state_next;
  logic               advance;

  assign advance  = tick_valid & (~out_valid | out_ready);
  assign in_ready = ~tick_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      torque_finish_limit <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      torque_finish_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick.host_command     <= host_command;
      tick.init_fault       <= init_fault;
      tick.ovp_test_result  <= ovp_test_result;
      tick.preflux_result   <= preflux_result;
      tick.discharge_result <= discharge_result;
      tick.torque_command   <= torque_command;
    end
  end

  css_next_state u_next (
    .cur                 (state),
    .tick                (tick),
    .torque_finish_limit (torque_finish_limit),
    .nxt                 (state_next)
  );

  // state register doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '{phase: PH_CHIP_INIT, faults: '0, init_ready: 1'b0};
      out_valid <= 1'b0;
    end else begin
      if (advance) state <= state_next;
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign phase           = state.phase;
  assign fault_flags     = state.faults;
  assign inverter_enable = (state.phase == PH_PREFLUX) |
                           (state.phase == PH_PREFLUX_DONE) |
                           (state.phase == PH_TQ_OUT);

  // a transfer into the state register always shows up as a result
  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("result lost after state update");

  // state only moves together with a tick leaving the input register
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without a tick transfer");

  // a stalled result keeps the waiting tick in the input register
  assert property (@(posedge clk) disable iff (rst)
    (tick_valid && out_valid && !out_ready) |=> tick_valid)
    else $error("waiting tick dropped during output stall");

  // only phase codes of the sequence are ever reached
  assert property (@(posedge clk) disable iff (rst) state.phase <= PH_FAULT)
    else $error("phase left the sequence");

endmodule
